/* src/cursor_list_table_defines.svh */
// assertion macros shared by the cursor list table rtl
`ifndef CURSOR_LIST_TABLE_DEFINES_SVH
`define CURSOR_LIST_TABLE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define CLT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent that forces a consequent, same or next cycle as written
`define CLT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define CLT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/clt_pkg.sv */
// shared constants for the cursor list table
package clt_pkg;

  // storage geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int KIND_W    = 4;
  localparam int STAT_W    = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_REPLACE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_START   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_END     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_PRIOR   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 4'd9;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BOUNDARY = 2'd3;

endpackage

/* src/clt_ram.sv */
// single write port, single registered read port ram
module clt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered and valid the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/cursor_list_table.sv */
// cursor list table: ordered word list in a ram with a cursor and a sequencer
// A request is taken when start is high and busy is low; its one result shows on the result
// ports for exactly one cycle, marked by done_o, and cannot be held off by the receiver, so it
// must be captured in that cycle. The entries live in a 16 x 32 ram with one write and one read
// port. Simple operations pass a fetch and a response state before idle again. Insert and
// remove move one entry per cycle through the ram port for the n entries behind the cursor
// that shift (1 to 14 for insert, 1 to 15 for remove), then pass a tail state, and insert
// also an inject state; with nothing to shift they go straight to the fetch state instead.
// Search reads one entry per cycle from the cursor on, at most DEPTH entries. The capacity
// register is written over its own valid/ready channel while idle.
`include "cursor_list_table_defines.svh"

module cursor_list_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [clt_pkg::KIND_W-1:0]       kind_i,
  input  logic [clt_pkg::WORD_BITS-1:0]    value_i,
  output logic                             done_o,
  output logic [clt_pkg::STAT_W-1:0]       status_o,
  output logic [clt_pkg::WORD_BITS-1:0]    cursor_word_o,
  output logic [clt_pkg::CNT_W-1:0]        entry_count_o,
  output logic [clt_pkg::IDX_W-1:0]        cursor_pos_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [clt_pkg::CNT_W-1:0]        cfg_capacity_i
);

  localparam int IDX_W = clt_pkg::IDX_W;
  localparam int CNT_W = clt_pkg::CNT_W;
  localparam int WB    = clt_pkg::WORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_TAIL   = 3'd2;
  localparam logic [2:0] ST_INJECT = 3'd3;
  localparam logic [2:0] ST_SRCH   = 3'd4;
  localparam logic [2:0] ST_FETCH  = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          cap_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          cursor_q, cursor_d;
  logic [WB-1:0]             value_q, value_d;
  logic [IDX_W-1:0]          src_q, src_d;
  logic [IDX_W-1:0]          end_q, end_d;
  logic [IDX_W-1:0]          lag_q, lag_d;
  logic                      pend_q, pend_d;
  logic                      issue_q, issue_d;
  logic                      up_q, up_d;
  logic [clt_pkg::STAT_W-1:0] stat_q, stat_d;
  logic                      done_q;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [WB-1:0]             wdata;
  logic [IDX_W-1:0]          raddr;
  logic [WB-1:0]             rdata;

  logic [CNT_W-1:0]          limit;
  logic [CNT_W-1:0]          cur_ext;
  logic                      empty;
  logic                      at_last;
  logic [IDX_W-1:0]          last_idx;
  logic [IDX_W-1:0]          cur_inc;
  logic                      accept;

  // entry storage
  clt_ram #(
    .DEPTH (clt_pkg::DEPTH),
    .WIDTH (WB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // handshakes
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  // derived list facts
  assign limit    = (cap_q > CNT_W'(clt_pkg::DEPTH)) ? CNT_W'(clt_pkg::DEPTH) : cap_q;
  assign cur_ext  = {1'b0, cursor_q};
  assign empty    = (count_q == '0);
  assign at_last  = ((cur_ext + CNT_W'(1)) == count_q);
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign cur_inc  = cursor_q + IDX_W'(1);

  // sequencer and ram port control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    value_d  = value_q;
    src_d    = src_q;
    end_d    = end_q;
    lag_d    = lag_q;
    pend_d   = 1'b0;
    issue_d  = issue_q;
    up_d     = up_q;
    stat_d   = stat_q;
    we       = 1'b0;
    waddr    = lag_q;
    wdata    = rdata;
    raddr    = cursor_q;

    // delayed write of a word moved during a shift
    if (pend_q && (state_q == ST_SHIFT || state_q == ST_TAIL)) begin
      we = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = value_i;
          stat_d  = clt_pkg::STAT_DONE;
          state_d = ST_FETCH;
          unique case (kind_i)
            clt_pkg::KIND_INSERT: begin
              if (count_q >= limit) begin
                stat_d = clt_pkg::STAT_FULL;
              end else if (empty) begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = value_i;
                cursor_d = '0;
                count_d  = CNT_W'(1);
              end else if (at_last) begin
                we       = 1'b1;
                waddr    = cur_inc;
                wdata    = value_i;
                cursor_d = cur_inc;
                count_d  = count_q + CNT_W'(1);
              end else begin
                src_d   = last_idx;
                end_d   = cur_inc;
                up_d    = 1'b1;
                state_d = ST_SHIFT;
              end
            end
            clt_pkg::KIND_REMOVE: begin
              if (empty) begin
                stat_d = clt_pkg::STAT_EMPTY;
              end else if (at_last) begin
                count_d  = count_q - CNT_W'(1);
                cursor_d = '0;
              end else begin
                src_d   = cur_inc;
                end_d   = last_idx;
                up_d    = 1'b0;
                state_d = ST_SHIFT;
              end
            end
            clt_pkg::KIND_REPLACE: begin
              if (empty) begin
                stat_d = clt_pkg::STAT_EMPTY;
              end else begin
                we    = 1'b1;
                waddr = cursor_q;
                wdata = value_i;
              end
            end
            clt_pkg::KIND_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            clt_pkg::KIND_START: begin
              if (empty) stat_d = clt_pkg::STAT_EMPTY;
              else cursor_d = '0;
            end
            clt_pkg::KIND_END: begin
              if (empty) stat_d = clt_pkg::STAT_EMPTY;
              else cursor_d = last_idx;
            end
            clt_pkg::KIND_NEXT: begin
              if (empty) stat_d = clt_pkg::STAT_EMPTY;
              else if (at_last) stat_d = clt_pkg::STAT_BOUNDARY;
              else cursor_d = cur_inc;
            end
            clt_pkg::KIND_PRIOR: begin
              if (empty) stat_d = clt_pkg::STAT_EMPTY;
              else if (cursor_q == '0) stat_d = clt_pkg::STAT_BOUNDARY;
              else cursor_d = cursor_q - IDX_W'(1);
            end
            clt_pkg::KIND_READ: begin
              if (empty) stat_d = clt_pkg::STAT_EMPTY;
            end
            clt_pkg::KIND_SEARCH: begin
              if (empty) begin
                stat_d = clt_pkg::STAT_EMPTY;
              end else begin
                src_d   = cursor_q;
                end_d   = last_idx;
                issue_d = 1'b1;
                state_d = ST_SRCH;
              end
            end
            default: begin
              // unused codes leave the list alone
            end
          endcase
        end
      end

      // stream one entry per cycle: read now, write one slot over next cycle
      ST_SHIFT: begin
        raddr  = src_q;
        pend_d = 1'b1;
        lag_d  = up_q ? (src_q + IDX_W'(1)) : (src_q - IDX_W'(1));
        if (src_q == end_q) begin
          state_d = ST_TAIL;
        end else begin
          src_d = up_q ? (src_q - IDX_W'(1)) : (src_q + IDX_W'(1));
        end
      end

      // last moved word lands this cycle
      ST_TAIL: begin
        if (up_q) begin
          state_d = ST_INJECT;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_FETCH;
        end
      end

      // new word goes into the gap after the cursor
      ST_INJECT: begin
        we       = 1'b1;
        waddr    = cur_inc;
        wdata    = value_q;
        cursor_d = cur_inc;
        count_d  = count_q + CNT_W'(1);
        state_d  = ST_FETCH;
      end

      // forward scan, compare in the cycle after the read
      ST_SRCH: begin
        if (pend_q && (rdata == value_q)) begin
          cursor_d = lag_q;
          stat_d   = clt_pkg::STAT_DONE;
          state_d  = ST_FETCH;
        end else if (pend_q && !issue_q) begin
          stat_d  = clt_pkg::STAT_BOUNDARY;
          state_d = ST_FETCH;
        end else begin
          raddr  = src_q;
          pend_d = 1'b1;
          lag_d  = src_q;
          if (src_q == end_q) begin
            issue_d = 1'b0;
          end else begin
            src_d = src_q + IDX_W'(1);
          end
        end
      end

      // read the word under the final cursor
      ST_FETCH: begin
        raddr   = cursor_q;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cap_q    <= clt_pkg::CAP_RESET;
      count_q  <= '0;
      cursor_q <= '0;
      pend_q   <= 1'b0;
      issue_q  <= 1'b0;
      up_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      pend_q   <= pend_d;
      issue_q  <= issue_d;
      up_q     <= up_d;
      done_q   <= (state_q == ST_RESP);
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_capacity_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    src_q   <= src_d;
    end_q   <= end_d;
    lag_q   <= lag_d;
    stat_q  <= stat_d;
    if (state_q == ST_RESP) begin
      status_o      <= stat_q;
      cursor_word_o <= empty ? '0 : rdata;
      entry_count_o <= count_q;
      cursor_pos_o  <= cursor_q;
    end
  end

  assign done_o = done_q;

  // checks
  `CLT_IMPLIES(a_cursor_in_list, !empty, cur_ext < count_q, "cursor beyond last entry")
  `CLT_IMPLIES(a_empty_cursor_home, empty, cursor_q == '0, "cursor not at start of empty list")
  `CLT_ASSERT(a_count_bound, count_q <= CNT_W'(clt_pkg::DEPTH), "entry count beyond depth")
  `CLT_NEXT(a_busy_after_accept, accept, busy, "request taken but sequencer idle")
  `CLT_IMPLIES(a_no_ram_collide, we && state_q == ST_SHIFT, waddr != raddr, "shift write hits read")
  `CLT_NEXT(a_single_strobe, done_o, !done_o, "result strobe held over two cycles")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the cursor list table with predictor, driver and result checker
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH     = clt_pkg::DEPTH;
  localparam int WORD_BITS = clt_pkg::WORD_BITS;
  localparam int IDX_W     = clt_pkg::IDX_W;
  localparam int CNT_W     = clt_pkg::CNT_W;
  localparam int KIND_W    = clt_pkg::KIND_W;
  localparam int STAT_W    = clt_pkg::STAT_W;

  // what one queued request asks of the driver
  typedef enum {REQ_OP, REQ_CAP, REQ_DRAIN} req_act_e;

  typedef struct {
    req_act_e               act;
    logic [KIND_W-1:0]      kind;
    logic [WORD_BITS-1:0]   value;
    logic [CNT_W-1:0]       cap;
  } list_req_t;

  // view of the list reported after one operation
  typedef struct {
    logic [STAT_W-1:0]      status;
    logic [WORD_BITS-1:0]   word;
    logic [CNT_W-1:0]       count;
    logic [IDX_W-1:0]       pos;
  } list_view_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [KIND_W-1:0]      kind_i = '0;
  logic [WORD_BITS-1:0]   value_i = '0;
  logic                   done_o;
  logic [STAT_W-1:0]      status_o;
  logic [WORD_BITS-1:0]   cursor_word_o;
  logic [CNT_W-1:0]       entry_count_o;
  logic [IDX_W-1:0]       cursor_pos_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_capacity_i = '0;

  list_req_t              pending_reqs[$];
  list_view_t             awaited_views[$];
  int                     outstanding = 0;
  int                     fail_count = 0;
  int                     burst_left = 1;
  int                     gap_left = 0;
  logic [WORD_BITS-1:0]   word_pool [8];

  // predictor copy of the list
  logic [WORD_BITS-1:0]   list_mem [DEPTH];
  int                     list_len = 0;
  int                     cur_idx = 0;
  int                     cap_reg = int'(clt_pkg::CAP_RESET);

  cursor_list_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .cursor_word_o  (cursor_word_o),
    .entry_count_o  (entry_count_o),
    .cursor_pos_o   (cursor_pos_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // apply one operation to the predicted list and return the view after it
  function automatic list_view_t apply_list_op(logic [KIND_W-1:0] op,
                                               logic [WORD_BITS-1:0] word);
    list_view_t res;
    int lim;
    int i;
    bit empty;
    logic [STAT_W-1:0] st;
    lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    empty = (list_len == 0);
    st = clt_pkg::STAT_DONE;
    case (op)
      clt_pkg::KIND_INSERT: begin
        if (list_len >= lim) begin
          st = clt_pkg::STAT_FULL;
        end else if (empty) begin
          list_mem[0] = word;
          cur_idx = 0;
          list_len = 1;
        end else begin
          for (i = list_len; i > cur_idx + 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[cur_idx+1] = word;
          cur_idx++;
          list_len++;
        end
      end
      clt_pkg::KIND_REMOVE: begin
        if (empty) begin
          st = clt_pkg::STAT_EMPTY;
        end else begin
          for (i = cur_idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          // removing the last entry sends the cursor back to the start
          if (cur_idx >= list_len) cur_idx = 0;
        end
      end
      clt_pkg::KIND_REPLACE: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
        else list_mem[cur_idx] = word;
      end
      clt_pkg::KIND_CLEAR: begin
        list_len = 0;
        cur_idx = 0;
      end
      clt_pkg::KIND_START: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
        else cur_idx = 0;
      end
      clt_pkg::KIND_END: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
        else cur_idx = list_len - 1;
      end
      clt_pkg::KIND_NEXT: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
        else if (cur_idx + 1 >= list_len) st = clt_pkg::STAT_BOUNDARY;
        else cur_idx++;
      end
      clt_pkg::KIND_PRIOR: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
        else if (cur_idx == 0) st = clt_pkg::STAT_BOUNDARY;
        else cur_idx--;
      end
      clt_pkg::KIND_READ: begin
        if (empty) st = clt_pkg::STAT_EMPTY;
      end
      clt_pkg::KIND_SEARCH: begin
        if (empty) begin
          st = clt_pkg::STAT_EMPTY;
        end else begin
          // forward from the cursor, cursor entry included
          st = clt_pkg::STAT_BOUNDARY;
          for (i = cur_idx; i < list_len; i++) begin
            if (list_mem[i] == word) begin
              cur_idx = i;
              st = clt_pkg::STAT_DONE;
              break;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (list_len == 0) cur_idx = 0;
    res.status = st;
    res.word = (list_len == 0) ? '0 : list_mem[cur_idx];
    res.count = list_len[CNT_W-1:0];
    res.pos = cur_idx[IDX_W-1:0];
    return res;
  endfunction

  // request queue helpers
  function automatic void add_op(logic [KIND_W-1:0] k, logic [WORD_BITS-1:0] v);
    list_req_t r;
    r.act = REQ_OP;
    r.kind = k;
    r.value = v;
    r.cap = '0;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_cap(logic [CNT_W-1:0] c);
    list_req_t r;
    r.act = REQ_CAP;
    r.kind = '0;
    r.value = '0;
    r.cap = c;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_drain();
    list_req_t r;
    r.act = REQ_DRAIN;
    r.kind = '0;
    r.value = '0;
    r.cap = '0;
    pending_reqs.push_back(r);
  endfunction

  // mostly pool words so that searches hit, with extremes and full random words
  function automatic logic [WORD_BITS-1:0] pick_word();
    logic [WORD_BITS-1:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2, 3: w = $urandom;
      default: w = word_pool[$urandom_range(0, 7)];
    endcase
    return w;
  endfunction

  // operation mix leaning toward growing or shrinking the list
  function automatic logic [KIND_W-1:0] pick_kind(bit grow);
    int r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < (grow ? 38 : 12)) k = clt_pkg::KIND_INSERT;
    else if (r < 50) k = clt_pkg::KIND_REMOVE;
    else if (r < 56) k = clt_pkg::KIND_REPLACE;
    else if (r < 58) k = clt_pkg::KIND_CLEAR;
    else if (r < 62) k = clt_pkg::KIND_START;
    else if (r < 66) k = clt_pkg::KIND_END;
    else if (r < 74) k = clt_pkg::KIND_NEXT;
    else if (r < 81) k = clt_pkg::KIND_PRIOR;
    else if (r < 85) k = clt_pkg::KIND_READ;
    else if (r < 97) k = clt_pkg::KIND_SEARCH;
    else k = KIND_W'($urandom_range(10, 15));
    return k;
  endfunction

  // request driver: bursts of requests with random gaps, config writes only when idle
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic                 nx_start;
    logic                 nx_cfg;
    logic [KIND_W-1:0]    nx_kind;
    logic [WORD_BITS-1:0] nx_value;
    logic [CNT_W-1:0]     nx_cap;
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= '0;
      value_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_capacity_i <= '0;
    end else begin
      nx_start = start;
      nx_cfg = cfg_valid_i;
      nx_kind = kind_i;
      nx_value = value_i;
      nx_cap = cfg_capacity_i;
      // retire a request taken at this edge
      if (start && !busy) begin
        void'(pending_reqs.pop_front());
        nx_start = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 25);
          endcase
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        void'(pending_reqs.pop_front());
        nx_cfg = 1'b0;
      end
      // present the next queued entry
      if (!nx_start && !nx_cfg && pending_reqs.size() > 0) begin
        case (pending_reqs[0].act)
          REQ_OP: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nx_start = 1'b1;
              nx_kind = pending_reqs[0].kind;
              nx_value = pending_reqs[0].value;
            end
          end
          REQ_CAP: begin
            if (!start && outstanding == 0) begin
              nx_cfg = 1'b1;
              nx_cap = pending_reqs[0].cap;
            end
          end
          default: begin
            if (!start && outstanding == 0) void'(pending_reqs.pop_front());
          end
        endcase
      end
      start <= nx_start;
      kind_i <= nx_kind;
      value_i <= nx_value;
      cfg_valid_i <= nx_cfg;
      cfg_capacity_i <= nx_cap;
    end
  end

  // result checker: predict on accept, compare on done strobe
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    list_view_t want;
    if (!rst_ni) begin
      outstanding <= 0;
    end else begin
      if (start && !busy) awaited_views.push_back(apply_list_op(kind_i, value_i));
      if (cfg_valid_i && cfg_ready_o) cap_reg = int'(cfg_capacity_i);
      if (done_o === 1'b1) begin
        if (awaited_views.size() == 0) begin
          $error("result with no request pending");
          fail_count++;
        end else begin
          want = awaited_views.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
          if (cursor_word_o !== want.word) begin
            $error("cursor_word: expected %08h, actual %08h", want.word, cursor_word_o);
            fail_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
            fail_count++;
          end
          if (cursor_pos_o !== want.pos) begin
            $error("cursor_pos: expected %0d, actual %0d", want.pos, cursor_pos_o);
            fail_count++;
          end
        end
      end
      outstanding <= outstanding + int'(start && !busy) - int'(done_o === 1'b1);
    end
  end

  // stimulus, reset and end of run
  initial begin : run_control
    int items_left;
    int prev_left;
    int seg_len;
    int run_len;
    int i;
    bit grow;
    logic [CNT_W-1:0] cap;
    logic [KIND_W-1:0] k;
    for (i = 0; i < 8; i++) word_pool[i] = $urandom;

    // empty list: every cursor operation reports empty
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(clt_pkg::KIND_REPLACE, 32'h1);
    add_op(clt_pkg::KIND_START, '0);
    add_op(clt_pkg::KIND_END, '0);
    add_op(clt_pkg::KIND_NEXT, '0);
    add_op(clt_pkg::KIND_PRIOR, '0);
    add_op(clt_pkg::KIND_READ, '0);
    add_op(clt_pkg::KIND_SEARCH, '0);
    // build a short list and walk it to both boundaries
    add_op(clt_pkg::KIND_INSERT, '0);
    add_op(clt_pkg::KIND_INSERT, '1);
    add_op(clt_pkg::KIND_INSERT, 32'h5a5a_5a5a);
    add_op(clt_pkg::KIND_PRIOR, '0);
    add_op(clt_pkg::KIND_PRIOR, '0);
    add_op(clt_pkg::KIND_PRIOR, '0);
    add_op(clt_pkg::KIND_NEXT, '0);
    add_op(clt_pkg::KIND_NEXT, '0);
    add_op(clt_pkg::KIND_NEXT, '0);
    // search misses behind the cursor, then hits from the start
    add_op(clt_pkg::KIND_SEARCH, '1);
    add_op(clt_pkg::KIND_START, '0);
    add_op(clt_pkg::KIND_SEARCH, '1);
    add_op(clt_pkg::KIND_REPLACE, 32'h1234_5678);
    add_op(clt_pkg::KIND_INSERT, 32'ha5a5_a5a5);
    add_op(clt_pkg::KIND_READ, '0);
    // remove the last entry so the cursor wraps, then remove at the start
    add_op(clt_pkg::KIND_END, '0);
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(4'd15, '0);
    add_op(4'd10, '0);
    add_op(clt_pkg::KIND_CLEAR, '0);

    // zero capacity: always full
    add_cap(5'd0);
    add_op(clt_pkg::KIND_INSERT, 32'h0bad_f00d);
    add_op(clt_pkg::KIND_READ, '0);
    // small capacity filled to its limit
    add_cap(5'd2);
    add_op(clt_pkg::KIND_INSERT, 32'h1);
    add_op(clt_pkg::KIND_INSERT, 32'h2);
    add_op(clt_pkg::KIND_INSERT, 32'h3);
    // capacity lowered below the count keeps entries
    add_cap(5'd1);
    add_op(clt_pkg::KIND_INSERT, 32'h4);
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(clt_pkg::KIND_INSERT, 32'h5);
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(clt_pkg::KIND_INSERT, 32'h6);
    // capacity above the array depth is clamped
    add_cap(5'd31);
    add_op(clt_pkg::KIND_CLEAR, '0);
    for (i = 0; i < 17; i++) add_op(clt_pkg::KIND_INSERT, pick_word());
    add_op(clt_pkg::KIND_START, '0);
    add_op(clt_pkg::KIND_SEARCH, word_pool[0]);
    add_op(clt_pkg::KIND_REMOVE, '0);
    add_op(clt_pkg::KIND_END, '0);
    add_op(clt_pkg::KIND_REMOVE, '0);

    // random segments, each under its own capacity
    items_left = 1200;
    while (items_left > 0) begin
      case ($urandom_range(0, 9))
        0: begin
          cap = CNT_W'($urandom_range(17, 31));
          seg_len = $urandom_range(40, 160);
        end
        1: begin
          cap = '0;
          seg_len = 10;
        end
        default: begin
          cap = CNT_W'($urandom_range(1, 16));
          seg_len = $urandom_range(40, 160);
        end
      endcase
      add_cap(cap);
      prev_left = items_left;
      while (seg_len > 0 && items_left > 0) begin
        grow = $urandom_range(0, 1);
        run_len = $urandom_range(10, 30);
        while (run_len > 0 && seg_len > 0 && items_left > 0) begin
          k = pick_kind(grow);
          add_op(k, pick_word());
          if (k <= clt_pkg::KIND_SEARCH) begin
            run_len--;
            seg_len--;
            items_left--;
          end
        end
      end
      // hold off halfway until all results are back
      if (items_left < 600 && prev_left >= 600) add_drain();
    end
    add_drain();
    add_cap(clt_pkg::CAP_RESET);
    add_op(clt_pkg::KIND_READ, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || outstanding != 0 || start || cfg_valid_i);
    repeat (40) @(negedge clk_i);
    if (awaited_views.size() != 0) begin
      $error("%0d results never arrived", awaited_views.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/clt_pkg.sv
src/clt_ram.sv
src/cursor_list_table.sv
tb/testbench.sv
